// ===== sv/ntwc_pkg.sv =====
// Shared types and constants for the number to word codes block.
// Used by ntwc_front, ntwc_queue, ntwc_back and number_to_word_codes_top.
package ntwc_pkg;

  // Input and output field geometry.
  localparam int VALUE_W    = 31;
  localparam int LEN_W      = 4;
  localparam int OP_W       = 2;
  localparam int CODE_W     = 6;
  localparam int DATA_IN_W  = 40;
  localparam int DATA_OUT_W = 8;
  localparam int LEN_LSB    = 31;
  localparam int LZ_BIT     = 35;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_CARDINAL = 2'd0;
  localparam logic [OP_W-1:0] OP_ORDINAL  = 2'd1;
  localparam logic [OP_W-1:0] OP_YEAR     = 2'd2;

  // Year mode treats tokens up to this many characters as years.
  localparam logic [LEN_W-1:0] YEAR_MAX_LEN   = 4'd4;
  localparam logic [LEN_W-1:0] YEAR_SHORT_LEN = 4'd2;

  // Word codes.
  localparam logic [CODE_W-1:0] WORD_ZERO     = 6'd0;
  localparam logic [CODE_W-1:0] WORD_TEN      = 6'd10;
  localparam logic [CODE_W-1:0] WORD_TWENTY   = 6'd20;
  localparam logic [CODE_W-1:0] WORD_HUNDRED  = 6'd28;
  localparam logic [CODE_W-1:0] WORD_THOUSAND = 6'd29;
  localparam logic [CODE_W-1:0] WORD_MILLION  = 6'd30;
  localparam logic [CODE_W-1:0] WORD_AND      = 6'd31;
  localparam logic [CODE_W-1:0] WORD_MINUS    = 6'd32;
  localparam logic [CODE_W-1:0] WORD_O        = 6'd33;

  // Binary to BCD conversion, two bits per cycle.
  localparam int DIGITS      = 10;
  localparam int BCD_W       = 4 * DIGITS;
  localparam int CONV_STEPS  = 16;
  localparam int SHIFT_W     = 2 * CONV_STEPS;

  // The spoken core is up to four groups of three digits.
  localparam int GROUPS       = 4;
  localparam int CORE_DIGITS  = 3 * GROUPS;
  localparam int SUFFIX_WORDS = 3;

  // Word slots: blocks of eight, lowest index spoken first.
  localparam int SLOT_W      = 6;
  localparam int SLOT_STRIDE = 8;
  localparam int NUM_SLOTS   = 43;

  localparam logic [2:0] BLK_HEAD   = 3'd0;
  localparam logic [2:0] BLK_SUFFIX = 3'd5;

  // Offsets in the head block.
  localparam logic [2:0] OFF_PRE_O = 3'd0;
  localparam logic [2:0] OFF_MINUS = 3'd1;
  localparam logic [2:0] OFF_ZERO  = 3'd2;

  // Offsets in a group block.
  localparam logic [2:0] OFF_AND_T   = 3'd0;
  localparam logic [2:0] OFF_H       = 3'd1;
  localparam logic [2:0] OFF_HUNDRED = 3'd2;
  localparam logic [2:0] OFF_AND_H   = 3'd3;
  localparam logic [2:0] OFF_TU1     = 3'd4;
  localparam logic [2:0] OFF_TU2     = 3'd5;
  localparam logic [2:0] OFF_SCALE   = 3'd6;

  // Group that carries the million scale word.
  localparam logic [1:0] GROUP_MILLION = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  // One classified number, ready for the word sequencer.
  typedef struct packed {
    logic [NUM_SLOTS-1:0]                  mask;
    logic [CORE_DIGITS-1:0][3:0]           core;
    logic [SUFFIX_WORDS-1:0][CODE_W-1:0]   suffix;
    logic                                  ordinal;
  } plan_t;

endpackage

// ===== sv/ntwc_front.sv =====
// Front end: accepts a number, converts its magnitude to BCD and builds the word plan.
// Depends on ntwc_pkg.
module ntwc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ntwc_pkg::OP_W-1:0]       operation,
  input  logic [ntwc_pkg::VALUE_W-1:0]    number_value,
  input  logic [ntwc_pkg::LEN_W-1:0]      text_length,
  input  logic                            leading_zero,
  input  logic                            american_style,
  output logic                            push,
  input  logic                            full,
  output ntwc_pkg::plan_t                 plan
);

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_PLAN} state_t;

  localparam int STEP_W = $clog2(ntwc_pkg::CONV_STEPS);

  state_t                             state;
  logic [STEP_W-1:0]                  step;
  logic [ntwc_pkg::SHIFT_W-1:0]       shifter;
  logic [ntwc_pkg::BCD_W-1:0]         bcd;
  logic [ntwc_pkg::OP_W-1:0]          op;
  logic                               neg;
  logic [ntwc_pkg::LEN_W-1:0]         len;
  logic                               lz;
  logic [ntwc_pkg::VALUE_W-1:0]       mag;

  // One double-dabble step: correct each digit, then shift in one bit.
  function automatic logic [ntwc_pkg::BCD_W-1:0] dabble(
    input logic [ntwc_pkg::BCD_W-1:0] b,
    input logic                       bit_in
  );
    logic [ntwc_pkg::BCD_W-1:0] a;
    a = b;
    for (int i = 0; i < ntwc_pkg::DIGITS; i++) begin
      if (a[4*i +: 4] >= 4'd5) begin
        a[4*i +: 4] = a[4*i +: 4] + 4'd3;
      end
    end
    return {a[ntwc_pkg::BCD_W-2:0], bit_in};
  endfunction

  assign mag = number_value[ntwc_pkg::VALUE_W-1] ? (~number_value + 1'b1) : number_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            op      <= operation;
            neg     <= number_value[ntwc_pkg::VALUE_W-1];
            len     <= text_length;
            lz      <= leading_zero;
            shifter <= {{(ntwc_pkg::SHIFT_W - ntwc_pkg::VALUE_W){1'b0}}, mag};
            bcd     <= '0;
            step    <= '0;
            state   <= F_CONV;
          end
        end
        F_CONV: begin
          bcd     <= dabble(dabble(bcd, shifter[ntwc_pkg::SHIFT_W-1]),
                            shifter[ntwc_pkg::SHIFT_W-2]);
          shifter <= {shifter[ntwc_pkg::SHIFT_W-3:0], 2'b00};
          step    <= step + 1'b1;
          if (step == STEP_W'(ntwc_pkg::CONV_STEPS - 1)) begin
            state <= F_PLAN;
          end
        end
        F_PLAN: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign in_ready = (state == F_IDLE);
  assign push     = (state == F_PLAN) && !full;

  // Classification of the converted number into word slots.
  always_comb begin : plan_build
    logic [ntwc_pkg::DIGITS-1:0][3:0]                      d;
    logic [ntwc_pkg::CORE_DIGITS-1:0][3:0]                 core;
    logic [ntwc_pkg::SUFFIX_WORDS-1:0][ntwc_pkg::CODE_W-1:0] suf;
    logic [ntwc_pkg::SUFFIX_WORDS-1:0]                     suf_en;
    logic [ntwc_pkg::GROUPS-1:0]                           grp_nz;
    logic [ntwc_pkg::NUM_SLOTS-1:0]                        mask;
    logic                                                  pre_o;
    logic                                                  pre_minus;
    logic                                                  core_en;
    logic                                                  mag_zero;
    logic                                                  below100;
    logic [3:0]                                            h;
    logic [3:0]                                            t;
    logic [3:0]                                            u;
    int                                                    base;

    d         = bcd;
    mag_zero  = (bcd == '0);
    below100  = (d[ntwc_pkg::DIGITS-1:2] == '0);
    core      = '0;
    core[ntwc_pkg::DIGITS-1:0] = d;
    suf       = '0;
    suf_en    = '0;
    pre_o     = 1'b0;
    pre_minus = neg;
    core_en   = 1'b1;

    if (op == ntwc_pkg::OP_YEAR && len <= ntwc_pkg::YEAR_MAX_LEN) begin
      if (lz && len == ntwc_pkg::YEAR_SHORT_LEN) begin
        pre_o = 1'b1;
        if (mag_zero) begin
          core_en   = 1'b0;
          suf[0]    = ntwc_pkg::WORD_O;
          suf_en[0] = 1'b1;
        end
      end else if (!neg && !below100) begin
        if (d[2] == 4'd0 && d[1] == 4'd0) begin
          // Whole thousands, possibly with a single unit after "and".
          core = '0;
          core[ntwc_pkg::DIGITS-4:0] = d[ntwc_pkg::DIGITS-1:3];
          suf[0]    = ntwc_pkg::WORD_THOUSAND;
          suf_en[0] = 1'b1;
          if (d[0] != 4'd0) begin
            suf[1]    = ntwc_pkg::WORD_AND;
            suf[2]    = {2'b00, d[0]};
            suf_en[1] = 1'b1;
            suf_en[2] = 1'b1;
          end
        end else begin
          core = '0;
          core[ntwc_pkg::DIGITS-3:0] = d[ntwc_pkg::DIGITS-1:2];
          suf_en[0] = 1'b1;
          if (d[1] == 4'd0 && d[0] == 4'd0) begin
            suf[0] = ntwc_pkg::WORD_HUNDRED;
          end else if (d[1] == 4'd0) begin
            suf[0]    = ntwc_pkg::WORD_O;
            suf[1]    = {2'b00, d[0]};
            suf_en[1] = 1'b1;
          end else if (d[1] == 4'd1) begin
            suf[0] = ntwc_pkg::WORD_TEN + {2'b00, d[0]};
          end else begin
            suf[0] = ntwc_pkg::WORD_TWENTY + {2'b00, d[1]} - 6'd2;
            if (d[0] != 4'd0) begin
              suf[1]    = {2'b00, d[0]};
              suf_en[1] = 1'b1;
            end
          end
        end
      end
    end

    for (int g = 0; g < ntwc_pkg::GROUPS; g++) begin
      grp_nz[g] = core_en && ({core[3*g+2], core[3*g+1], core[3*g]} != 12'd0);
    end

    mask = '0;
    mask[int'(ntwc_pkg::BLK_HEAD) * ntwc_pkg::SLOT_STRIDE + int'(ntwc_pkg::OFF_PRE_O)] = pre_o;
    mask[int'(ntwc_pkg::BLK_HEAD) * ntwc_pkg::SLOT_STRIDE + int'(ntwc_pkg::OFF_MINUS)] = pre_minus;
    mask[int'(ntwc_pkg::BLK_HEAD) * ntwc_pkg::SLOT_STRIDE + int'(ntwc_pkg::OFF_ZERO)] =
      core_en && (core == '0);

    for (int g = 0; g < ntwc_pkg::GROUPS; g++) begin
      h    = core[3*g+2];
      t    = core[3*g+1];
      u    = core[3*g];
      base = (ntwc_pkg::GROUPS - g) * ntwc_pkg::SLOT_STRIDE;
      mask[base + int'(ntwc_pkg::OFF_H)]       = core_en && (h != 4'd0);
      mask[base + int'(ntwc_pkg::OFF_HUNDRED)] = core_en && (h != 4'd0);
      mask[base + int'(ntwc_pkg::OFF_AND_H)]   = core_en && (h != 4'd0) &&
                                                 ({t, u} != 8'd0) && !american_style;
      mask[base + int'(ntwc_pkg::OFF_TU1)]     = core_en && ({t, u} != 8'd0);
      mask[base + int'(ntwc_pkg::OFF_TU2)]     = core_en && (t >= 4'd2) && (u != 4'd0);
    end

    // "And" after a thousand when the following group is below one hundred.
    mask[(ntwc_pkg::GROUPS - 2) * ntwc_pkg::SLOT_STRIDE + int'(ntwc_pkg::OFF_AND_T)] =
      grp_nz[3] && grp_nz[2] && (core[8] == 4'd0);
    mask[ntwc_pkg::GROUPS * ntwc_pkg::SLOT_STRIDE + int'(ntwc_pkg::OFF_AND_T)] =
      grp_nz[1] && grp_nz[0] && (core[2] == 4'd0);

    // Scale words: thousand within the million count, million, thousand.
    mask[(ntwc_pkg::GROUPS - 3) * ntwc_pkg::SLOT_STRIDE + int'(ntwc_pkg::OFF_SCALE)] = grp_nz[3];
    mask[(ntwc_pkg::GROUPS - 2) * ntwc_pkg::SLOT_STRIDE + int'(ntwc_pkg::OFF_SCALE)] =
      grp_nz[3] || grp_nz[2];
    mask[(ntwc_pkg::GROUPS - 1) * ntwc_pkg::SLOT_STRIDE + int'(ntwc_pkg::OFF_SCALE)] = grp_nz[1];

    for (int k = 0; k < ntwc_pkg::SUFFIX_WORDS; k++) begin
      mask[int'(ntwc_pkg::BLK_SUFFIX) * ntwc_pkg::SLOT_STRIDE + k] = suf_en[k];
    end

    plan.mask    = mask;
    plan.core    = core;
    plan.suffix  = suf;
    plan.ordinal = (op == ntwc_pkg::OP_ORDINAL);
  end

endmodule

// ===== sv/ntwc_queue.sv =====
// Short queue of word plans between the front end and the word sequencer.
// Depends on ntwc_pkg for the plan type.
module ntwc_queue #(
  parameter int DEPTH = ntwc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ntwc_pkg::plan_t push_data,
  output logic            full,
  input  logic            pop,
  output ntwc_pkg::plan_t head,
  output logic            not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ntwc_pkg::plan_t    entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/ntwc_back.sv =====
// Word sequencer: walks the enabled slots of a plan and delivers one word per transfer.
// Depends on ntwc_pkg.
module ntwc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  ntwc_pkg::plan_t               q_head,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ntwc_pkg::CODE_W-1:0]   out_code,
  output logic                          out_ordinal,
  output logic                          out_last
);

  logic                                                    busy;
  logic [ntwc_pkg::NUM_SLOTS-1:0]                          mask;
  logic [ntwc_pkg::CORE_DIGITS-1:0][3:0]                   core;
  logic [ntwc_pkg::SUFFIX_WORDS-1:0][ntwc_pkg::CODE_W-1:0] suffix;
  logic                                                    ordinal;

  logic [ntwc_pkg::NUM_SLOTS-1:0]        onehot;
  logic [ntwc_pkg::NUM_SLOTS-1:0]        rest;
  logic [ntwc_pkg::SLOT_W-1:0]           idx;
  logic [2:0]                            blk;
  logic [2:0]                            off;
  logic [1:0]                            grp;
  logic [ntwc_pkg::GROUPS-1:0][2:0][3:0] grp_digits;
  logic [3:0]                            h;
  logic [3:0]                            t;
  logic [3:0]                            u;
  logic [ntwc_pkg::CODE_W-1:0]           tu_code;
  logic [ntwc_pkg::CODE_W-1:0]           code;
  logic                                  last;
  logic                                  adv;
  logic                                  load;

  // Lowest enabled slot is the next word; the word is last when nothing else remains.
  assign onehot = mask & (~mask + 1'b1);
  assign rest   = mask & ~onehot;
  assign last   = (rest == '0);

  always_comb begin
    idx = '0;
    for (int i = 0; i < ntwc_pkg::NUM_SLOTS; i++) begin
      if (onehot[i]) begin
        idx = idx | ntwc_pkg::SLOT_W'(i);
      end
    end
  end

  assign blk        = idx[ntwc_pkg::SLOT_W-1:3];
  assign off        = idx[2:0];
  assign grp        = 2'(3'(ntwc_pkg::GROUPS) - blk);
  assign grp_digits = core;
  assign h          = grp_digits[grp][2];
  assign t          = grp_digits[grp][1];
  assign u          = grp_digits[grp][0];

  always_comb begin
    if (t == 4'd0) begin
      tu_code = {2'b00, u};
    end else if (t == 4'd1) begin
      tu_code = ntwc_pkg::WORD_TEN + {2'b00, u};
    end else begin
      tu_code = ntwc_pkg::WORD_TWENTY + {2'b00, t} - 6'd2;
    end
  end

  always_comb begin
    case (blk)
      ntwc_pkg::BLK_HEAD: begin
        case (off)
          ntwc_pkg::OFF_PRE_O: code = ntwc_pkg::WORD_O;
          ntwc_pkg::OFF_MINUS: code = ntwc_pkg::WORD_MINUS;
          default:             code = ntwc_pkg::WORD_ZERO;
        endcase
      end
      ntwc_pkg::BLK_SUFFIX: begin
        case (off)
          3'd0:    code = suffix[0];
          3'd1:    code = suffix[1];
          default: code = suffix[2];
        endcase
      end
      default: begin
        case (off)
          ntwc_pkg::OFF_AND_T:   code = ntwc_pkg::WORD_AND;
          ntwc_pkg::OFF_H:       code = {2'b00, h};
          ntwc_pkg::OFF_HUNDRED: code = ntwc_pkg::WORD_HUNDRED;
          ntwc_pkg::OFF_AND_H:   code = ntwc_pkg::WORD_AND;
          ntwc_pkg::OFF_TU1:     code = tu_code;
          ntwc_pkg::OFF_TU2:     code = {2'b00, u};
          ntwc_pkg::OFF_SCALE:   code = (grp == ntwc_pkg::GROUP_MILLION) ?
                                        ntwc_pkg::WORD_MILLION : ntwc_pkg::WORD_THOUSAND;
          default:               code = ntwc_pkg::WORD_ZERO;
        endcase
      end
    endcase
  end

  assign adv   = busy && (!out_valid || out_ready);
  assign load  = q_valid && (!busy || (adv && last));
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid   <= 1'b1;
        out_code    <= code;
        out_ordinal <= ordinal && last;
        out_last    <= last;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      // A new plan replaces the finished one in the same cycle as its last word.
      if (load) begin
        busy    <= 1'b1;
        mask    <= q_head.mask;
        core    <= q_head.core;
        suffix  <= q_head.suffix;
        ordinal <= q_head.ordinal;
      end else if (adv) begin
        mask <= rest;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sv/number_to_word_codes_top.sv =====
// Top level of the number to word codes block: configuration register and the three parts.
// Depends on ntwc_pkg, ntwc_front, ntwc_queue and ntwc_back.
//
// Usage. Each transfer on the slave stream carries one numeric token: its value as a
// signed integer, its written length and a leading-zero flag in tdata, and the reading
// mode (cardinal, ordinal or year) in tuser. The master stream then delivers the English
// words of that number, one word code per transfer, in speaking order. The final word of
// the number is marked by tlast, and tuser is set on it when the number is an ordinal.
// Every token gives at least one word and at most eighteen.
// Timing. The front end accepts a token, converts it from binary to BCD at two bits per
// cycle, and then classifies it into a word plan. The word sequencer delivers one word
// per cycle while it holds a plan and the receiver is ready. The queue between the two
// parts lets the front end convert the next token while the sequencer is still
// delivering words of an earlier one.
// Reset clears the queue, the sequencer and the register (British style). When the
// receiver holds tready low the current word waits in the output register. The slave
// side's tready is low from each transfer until the front end has handed its plan on, and
// once the queue is full it stays low until room appears, so no word is ever lost.
// The style register may be written only while no token is in flight.
module number_to_word_codes_top #(
  parameter int QUEUE_DEPTH = ntwc_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // number_value [30:0], text_length [34:31], leading_zero [35], zero fill [39:36]
  input  logic [ntwc_pkg::DATA_IN_W-1:0]     s_axis_tdata,
  // operation [1:0]
  input  logic [ntwc_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // word_code [5:0], zero fill [7:6]
  output logic [ntwc_pkg::DATA_OUT_W-1:0]    m_axis_tdata,
  // ordinal_form [0]
  output logic                               m_axis_tuser,
  // last_word
  output logic                               m_axis_tlast
);

  logic                               american_style;
  logic                               push;
  logic                               full;
  logic                               pop;
  logic                               not_empty;
  ntwc_pkg::plan_t                    push_plan;
  ntwc_pkg::plan_t                    head_plan;
  logic [ntwc_pkg::CODE_W-1:0]        word_code;

  // Style register: set for American English, which drops "and" after "hundred".
  always_ff @(posedge clk) begin
    if (rst) begin
      american_style <= 1'b0;
    end else if (cfg_wr_en) begin
      american_style <= cfg_wr_data;
    end
  end

  ntwc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .operation      (s_axis_tuser),
    .number_value   (s_axis_tdata[ntwc_pkg::VALUE_W-1:0]),
    .text_length    (s_axis_tdata[ntwc_pkg::LEN_LSB +: ntwc_pkg::LEN_W]),
    .leading_zero   (s_axis_tdata[ntwc_pkg::LZ_BIT]),
    .american_style (american_style),
    .push           (push),
    .full           (full),
    .plan           (push_plan)
  );

  ntwc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_plan),
    .full      (full),
    .pop       (pop),
    .head      (head_plan),
    .not_empty (not_empty)
  );

  ntwc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (not_empty),
    .q_pop       (pop),
    .q_head      (head_plan),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_code    (word_code),
    .out_ordinal (m_axis_tuser),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {{(ntwc_pkg::DATA_OUT_W - ntwc_pkg::CODE_W){1'b0}}, word_code};

endmodule
